// File: design/absm_pkg.sv
// ----------------------------------------------------------------------------
// absm_pkg
// Shared types and constants of the A/B boot slot manager.
// ----------------------------------------------------------------------------
package absm_pkg;

  localparam int unsigned NumSlots   = 2;
  localparam int unsigned QueueDepth = 2;

  // slot modes
  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_ACTIVE   = 2'd1;
  localparam logic [1:0] MODE_BOOTING  = 2'd2;
  localparam logic [1:0] MODE_INVALID  = 2'd3;

  // action codes as they arrive on the input stream
  localparam logic [3:0] ACT_LOAD     = 4'd0;
  localparam logic [3:0] ACT_SELECT   = 4'd1;
  localparam logic [3:0] ACT_SUCCESS  = 4'd2;
  localparam logic [3:0] ACT_FAILED   = 4'd3;
  localparam logic [3:0] ACT_STANDBY  = 4'd4;
  localparam logic [3:0] ACT_SWITCH   = 4'd5;
  localparam logic [3:0] ACT_ROLLBACK = 4'd6;
  localparam logic [3:0] ACT_CHECK    = 4'd7;
  localparam logic [3:0] ACT_READ     = 4'd8;

  // decoded operation
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SELECT,
    OP_SUCCESS,
    OP_FAILED,
    OP_STANDBY,
    OP_SWITCH,
    OP_ROLLBACK,
    OP_CHECK,
    OP_READ,
    OP_BAD
  } op_e;

  // classified event as held in the queue
  typedef struct packed {
    op_e         op;
    logic        idx;        // slot read by a metadata read
    logic        idx_bad;    // slot index out of range
    logic [31:0] version;
    logic        over_limit; // boot count above the limit register
  } item_t;

  // one result beat
  typedef struct packed {
    logic        priority_f;
    logic [31:0] version;
    logic [7:0]  attempts;
    logic        boot_ok;
    logic        bootable;
    logic [1:0]  state;
    logic        clear_cnt;
    logic        reboot_request;
    logic        limit_exceeded;
    logic        standby_slot;
    logic        boot_sel;
    logic        status;
  } result_t;

endpackage

// File: design/absm_front.sv
// ----------------------------------------------------------------------------
// absm_front
// Accepts input beats, decodes the action and classifies the operands.
// ----------------------------------------------------------------------------
module absm_front (
  input  logic                 in_valid_i,
  input  logic [3:0]           action_i,
  input  logic [7:0]           slot_index_i,
  input  logic [31:0]          new_version_i,
  input  logic [31:0]          boot_cnt_i,
  input  logic [15:0]          limit_i,
  input  logic                 q_ready_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output absm_pkg::item_t      item_o
);

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    item_o            = '0;
    item_o.idx        = slot_index_i[0];
    item_o.idx_bad    = (slot_index_i[7:1] != 7'd0);
    item_o.version    = new_version_i;
    item_o.over_limit = (boot_cnt_i > {16'd0, limit_i});
    case (action_i)
      absm_pkg::ACT_LOAD:     item_o.op = absm_pkg::OP_LOAD;
      absm_pkg::ACT_SELECT:   item_o.op = absm_pkg::OP_SELECT;
      absm_pkg::ACT_SUCCESS:  item_o.op = absm_pkg::OP_SUCCESS;
      absm_pkg::ACT_FAILED:   item_o.op = absm_pkg::OP_FAILED;
      absm_pkg::ACT_STANDBY:  item_o.op = absm_pkg::OP_STANDBY;
      absm_pkg::ACT_SWITCH:   item_o.op = absm_pkg::OP_SWITCH;
      absm_pkg::ACT_ROLLBACK: item_o.op = absm_pkg::OP_ROLLBACK;
      absm_pkg::ACT_CHECK:    item_o.op = absm_pkg::OP_CHECK;
      absm_pkg::ACT_READ:     item_o.op = absm_pkg::OP_READ;
      default:                item_o.op = absm_pkg::OP_BAD;
    endcase
  end

endmodule

// File: design/absm_queue.sv
// ----------------------------------------------------------------------------
// absm_queue
// Small FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module absm_queue #(
  parameter int unsigned Depth = absm_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  absm_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output absm_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  absm_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue push while full");

endmodule

// File: design/absm_back.sv
// ----------------------------------------------------------------------------
// absm_back
// Executes queued events against the slot state and registers the result.
// ----------------------------------------------------------------------------
module absm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  absm_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output absm_pkg::result_t result_o
);

  localparam int unsigned N = absm_pkg::NumSlots;

  logic [1:0]  mode_q [N];
  logic [1:0]  mode_d [N];
  logic        can_q [N];
  logic        can_d [N];
  logic        ok_q [N];
  logic        ok_d [N];
  logic [7:0]  tries_q [N];
  logic [7:0]  tries_d [N];
  logic [31:0] major_q [N];
  logic [31:0] major_d [N];

  logic hdr_active_q, hdr_active_d;
  logic hdr_boot_q, hdr_boot_d;
  logic c_active_q, c_active_d;
  logic c_standby_q, c_standby_d;
  logic loaded_q, loaded_d;

  logic              out_valid_q;
  absm_pkg::result_t out_q, res;

  logic a_ok, b_ok, none_ok, pick;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  // Priorities are fixed at rank = slot index, so with both slots eligible
  // slot 1 always wins and the version tie-break never comes into play.
  assign a_ok    = can_q[0] && (mode_q[0] == absm_pkg::MODE_ACTIVE);
  assign b_ok    = can_q[1] && (mode_q[1] == absm_pkg::MODE_ACTIVE);
  assign none_ok = !a_ok && !b_ok;
  assign pick    = b_ok;

  always_comb begin
    mode_d       = mode_q;
    can_d        = can_q;
    ok_d         = ok_q;
    tries_d      = tries_q;
    major_d      = major_q;
    hdr_active_d = hdr_active_q;
    hdr_boot_d   = hdr_boot_q;
    c_active_d   = c_active_q;
    c_standby_d  = c_standby_q;
    loaded_d     = loaded_q;
    res          = '0;
    res.boot_sel = c_active_q;

    if (!loaded_q && (item_i.op inside {absm_pkg::OP_SELECT, absm_pkg::OP_SUCCESS,
        absm_pkg::OP_FAILED, absm_pkg::OP_STANDBY, absm_pkg::OP_SWITCH,
        absm_pkg::OP_ROLLBACK, absm_pkg::OP_CHECK})) begin
      res.status = 1'b1;
    end else begin
      case (item_i.op)
        absm_pkg::OP_LOAD: begin
          loaded_d     = 1'b1;
          c_active_d   = hdr_active_q;
          c_standby_d  = ~hdr_active_q;
          res.boot_sel = hdr_active_q;
        end
        absm_pkg::OP_SELECT: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == pick) begin
              // fallback revives slot 0 with a cleared count before the bump
              if (none_ok) begin
                tries_d[i] = 8'd1;
              end else if (tries_q[i] != 8'hFF) begin
                tries_d[i] = tries_q[i] + 8'd1;
              end
              mode_d[i] = absm_pkg::MODE_BOOTING;
            end
          end
          hdr_boot_d   = pick;
          res.boot_sel = pick;
        end
        absm_pkg::OP_SUCCESS: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == hdr_boot_q) begin
              mode_d[i]  = absm_pkg::MODE_ACTIVE;
              ok_d[i]    = 1'b1;
              tries_d[i] = 8'd0;
            end
          end
          hdr_active_d  = hdr_boot_q;
          c_active_d    = hdr_boot_q;
          c_standby_d   = ~hdr_boot_q;
          res.boot_sel  = hdr_boot_q;
          res.clear_cnt = 1'b1;
        end
        absm_pkg::OP_FAILED: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == hdr_boot_q) begin
              mode_d[i] = absm_pkg::MODE_INVALID;
              ok_d[i]   = 1'b0;
            end
          end
        end
        absm_pkg::OP_STANDBY: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == c_standby_q) begin
              can_d[i]   = 1'b1;
              mode_d[i]  = absm_pkg::MODE_INACTIVE;
              major_d[i] = item_i.version;
            end
            if (1'(i) == c_active_q) begin
              mode_d[i] = absm_pkg::MODE_INACTIVE;
              can_d[i]  = 1'b0;
            end
          end
        end
        absm_pkg::OP_SWITCH: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == c_standby_q) begin
              mode_d[i] = absm_pkg::MODE_ACTIVE;
            end
          end
          hdr_active_d       = c_standby_q;
          res.boot_sel       = c_standby_q;
          res.reboot_request = 1'b1;
        end
        absm_pkg::OP_ROLLBACK: begin
          for (int i = 0; i < N; i++) begin
            if (1'(i) == hdr_active_q) begin
              mode_d[i] = absm_pkg::MODE_INVALID;
              can_d[i]  = 1'b0;
            end else begin
              mode_d[i] = absm_pkg::MODE_ACTIVE;
              can_d[i]  = 1'b1;
            end
          end
          hdr_active_d = ~hdr_active_q;
          c_active_d   = ~hdr_active_q;
          c_standby_d  = hdr_active_q;
          res.boot_sel = ~hdr_active_q;
        end
        absm_pkg::OP_CHECK: begin
          res.limit_exceeded = item_i.over_limit;
        end
        absm_pkg::OP_READ: begin
          if (item_i.idx_bad) begin
            res.status = 1'b1;
          end else begin
            res.state      = item_i.idx ? mode_q[1]  : mode_q[0];
            res.bootable   = item_i.idx ? can_q[1]   : can_q[0];
            res.boot_ok    = item_i.idx ? ok_q[1]    : ok_q[0];
            res.attempts   = item_i.idx ? tries_q[1] : tries_q[0];
            res.version    = item_i.idx ? major_q[1] : major_q[0];
            res.priority_f = item_i.idx;
          end
        end
        default: begin
          res.status = 1'b1;
        end
      endcase
    end
    res.standby_slot = c_standby_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q[0]    <= absm_pkg::MODE_ACTIVE;
      mode_q[1]    <= absm_pkg::MODE_INACTIVE;
      can_q[0]     <= 1'b1;
      can_q[1]     <= 1'b0;
      for (int i = 0; i < N; i++) begin
        ok_q[i]    <= 1'b0;
        tries_q[i] <= 8'd0;
        major_q[i] <= 32'd0;
      end
      hdr_active_q <= 1'b0;
      hdr_boot_q   <= 1'b0;
      c_active_q   <= 1'b0;
      c_standby_q  <= 1'b0;
      loaded_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q       <= mode_d;
        can_q        <= can_d;
        ok_q         <= ok_d;
        tries_q      <= tries_d;
        major_q      <= major_d;
        hdr_active_q <= hdr_active_d;
        hdr_boot_q   <= hdr_boot_d;
        c_active_q   <= c_active_d;
        c_standby_q  <= c_standby_d;
        loaded_q     <= loaded_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  a_pop_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("executed event produced no result");

  a_loaded_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |=> loaded_q)
    else $error("loaded flag dropped");

  a_caches_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> (c_active_q != c_standby_q))
    else $error("cached active and standby slots coincide");

  a_one_side_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.reboot_request && out_q.clear_cnt))
    else $error("reboot and counter clear in one result");

endmodule

// File: design/ab_boot_slot_manager_core.sv
// ----------------------------------------------------------------------------
// ab_boot_slot_manager_core
// Two-slot A/B boot manager: event stream in, one result beat per event out.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tuser action, tdata operands
//  m_axis    | out | m_axis_tvalid/tready    | tdata result fields
//  apb       | in  | psel/penable/pready     | boot count limit at 0x0
//
//  One event per cycle sustained while the output is not stalled. Front
//  decodes and compares the boot count, a small FIFO decouples it from the
//  back, which updates the slot state and loads the output register in the
//  same cycle. Either side may stall: the FIFO absorbs input while the output
//  beat waits. Reset is asynchronous, active low; no clearing pass.
//
module ab_boot_slot_manager_core #(
  parameter int unsigned QUEUE_DEPTH = absm_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // slot_index[7:0], new_version[39:8],
                                     // boot_cnt[71:40]
  input  logic [3:0]  s_axis_tuser,  // action[3:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // status[0], boot_sel[1],
                                     // standby_slot[2], limit_exceeded[3],
                                     // reboot_request[4], clear_cnt[5],
                                     // meta_state[7:6], meta_bootable[8],
                                     // meta_boot_ok[9], meta_attempts[17:10],
                                     // meta_version[49:18], meta_priority[50],
                                     // zero[55:51]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]       limit_q;
  logic              cfg_wr;
  logic              q_full, q_valid, push, pop;
  absm_pkg::item_t   f_item, q_item;
  absm_pkg::result_t res;

  // config register; the user must write it only while idle, the block itself does not enforce this
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd3;
    end else if (cfg_wr) begin
      limit_q <= pwdata[15:0];
    end
  end

  absm_front u_front (
    .in_valid_i    (s_axis_tvalid),
    .action_i      (s_axis_tuser),
    .slot_index_i  (s_axis_tdata[7:0]),
    .new_version_i (s_axis_tdata[39:8]),
    .boot_cnt_i    (s_axis_tdata[71:40]),
    .limit_i       (limit_q),
    .q_ready_i     (!q_full),
    .in_ready_o    (s_axis_tready),
    .push_o        (push),
    .item_o        (f_item)
  );

  absm_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  absm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule
